// ===== hw/rtl/irqct_pkg.sv =====
// Package for the interrupt completion tracker.
// Holds command and observe codes, the state record and the result record.
// No dependencies.
package irqct_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned FuncW  = 3;
	localparam int unsigned ObsW   = 2;
	localparam int unsigned CfgIdxW = 1;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [FuncW-1:0] {
		FUNC_CLEAR    = 3'd0,
		FUNC_ENABLE   = 3'd1,
		FUNC_DISABLE  = 3'd2,
		FUNC_BEGIN    = 3'd3,
		FUNC_RECORD   = 3'd4,
		FUNC_OBSERVE  = 3'd5,
		FUNC_FINISH   = 3'd6,
		FUNC_FALLBACK = 3'd7
	} func_t;

	typedef enum logic [ObsW-1:0] {
		OBS_NONE     = 2'd0,
		OBS_COMPLETE = 2'd1,
		OBS_ERROR    = 2'd2
	} obs_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_COMPLETION_MASK = 1'd0,
		CFG_ERROR_MASK      = 1'd1
	} cfg_idx_t;

	typedef struct packed {
		word_t cur_gen;
		word_t seen_gen;
		word_t acc_status;
		word_t irq_cnt;
		word_t fb_cnt;
		logic  enabled;
		logic  active;
	} state_t;

	typedef struct packed {
		word_t cmp_mask;
		word_t err_mask;
	} masks_t;

	typedef struct packed {
		word_t new_gen;
		logic  fin;
		obs_t  obs;
	} step_res_t;

endpackage

// ===== hw/rtl/irqct_if.sv =====
// Valid/ready channel interfaces for the tracker's request and result sides.
// Depends on irqct_pkg.
interface irqct_req_if
	import irqct_pkg::*;
();
	logic  valid;
	logic  ready;
	func_t func;
	word_t status;
	word_t generation;

	modport source (output valid, output func, output status, output generation, input ready);
	modport sink (input valid, input func, input status, input generation, output ready);
endinterface

interface irqct_rsp_if
	import irqct_pkg::*;
();
	logic  valid;
	logic  ready;
	word_t new_generation;
	logic  finish_done;
	obs_t  observe_result;
	logic  enabled_now;
	logic  active_now;
	word_t status_seen;
	word_t interrupt_total;
	word_t fallback_total;

	modport source (output valid, output new_generation, output finish_done,
		output observe_result, output enabled_now, output active_now,
		output status_seen, output interrupt_total, output fallback_total, input ready);
	modport sink (input valid, input new_generation, input finish_done,
		input observe_result, input enabled_now, input active_now,
		input status_seen, input interrupt_total, input fallback_total, output ready);
endinterface

// ===== hw/rtl/irq_completion_tracker.sv =====
// Interrupt completion tracker: requests pass an input register, then a result register.
// One request per cycle while results are taken; a full result register does not block
// intake while the input register is free; both advance together when the result is taken.
// The step logic reads tracker state and writes it back in the same cycle it loads the result.
// Reset (arst_n low) clears tracker state, both masks and the valid flags.
// Depends on irqct_pkg, irqct_if and irqct_step.
module irq_completion_tracker
	import irqct_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  word_t          cfg_wdata,
	irqct_req_if.sink      req,
	irqct_rsp_if.source    rsp
);

	logic      valid_s1;
	func_t     func_s1;
	word_t     status_s1;
	word_t     tag_s1;

	logic      rsp_valid_q;
	step_res_t res_q;

	state_t    st_q;
	state_t    st_nxt;
	masks_t    masks_q;
	step_res_t res_nxt;

	logic      adv_out;
	logic      fire;

	assign adv_out   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && adv_out;
	assign req.ready = !valid_s1 || adv_out;

	irqct_step u_step (
		.st     (st_q),
		.masks  (masks_q),
		.func   (func_s1),
		.status (status_s1),
		.tag    (tag_s1),
		.nxt    (st_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMPLETION_MASK: masks_q.cmp_mask <= cfg_wdata;
				CFG_ERROR_MASK:      masks_q.err_mask <= cfg_wdata;
				default:             masks_q <= masks_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1   <= req.func;
			status_s1 <= req.status;
			tag_s1    <= req.generation;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv_out)
				rsp_valid_q <= valid_s1;
			if (fire)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_nxt;
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.new_generation  = res_q.new_gen;
	assign rsp.finish_done     = res_q.fin;
	assign rsp.observe_result  = res_q.obs;
	// result snapshot fields always track state: both load on the same request
	assign rsp.enabled_now     = st_q.enabled;
	assign rsp.active_now      = st_q.active;
	assign rsp.status_seen     = st_q.acc_status;
	assign rsp.interrupt_total = st_q.irq_cnt;
	assign rsp.fallback_total  = st_q.fb_cnt;

	a_active_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active |-> st_q.enabled)
		else $error("active without enable");

	a_active_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active |-> st_q.cur_gen != '0)
		else $error("active generation is zero");

	a_seen_is_current: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seen_gen != '0 |-> (st_q.seen_gen == st_q.cur_gen && st_q.active))
		else $error("seen generation stale");

	a_status_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.acc_status != '0 |-> st_q.active)
		else $error("status accumulated while idle");

	a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> $stable(st_q))
		else $error("state moved while result stalled");

endmodule

// ===== hw/rtl/irqct_step.sv =====
// Next-state and result logic for one tracker request.
// Depends on irqct_pkg.
module irqct_step
	import irqct_pkg::*;
(
	input  state_t    st,
	input  masks_t    masks,
	input  func_t     func,
	input  word_t     status,
	input  word_t     tag,
	output state_t    nxt,
	output step_res_t res
);

	word_t gen_inc;
	logic  tag_hit;

	assign gen_inc = (st.cur_gen + 1'b1 == '0) ? word_t'(1) : st.cur_gen + 1'b1;
	// zero tag never matches
	assign tag_hit = (tag != '0) && (st.cur_gen == tag);

	always_comb begin
		nxt = st;
		res.new_gen = '0;
		res.fin = 1'b0;
		res.obs = OBS_NONE;
		unique case (func)
			FUNC_CLEAR: begin
				nxt = '0;
			end
			FUNC_ENABLE: begin
				nxt.enabled = 1'b1;
			end
			FUNC_DISABLE: begin
				nxt.enabled = 1'b0;
				nxt.active = 1'b0;
				nxt.seen_gen = '0;
				nxt.acc_status = '0;
			end
			FUNC_BEGIN: begin
				if (st.enabled && !st.active) begin
					nxt.cur_gen = gen_inc;
					nxt.seen_gen = '0;
					nxt.acc_status = '0;
					nxt.active = 1'b1;
					res.new_gen = gen_inc;
				end
			end
			FUNC_RECORD: begin
				if (st.enabled && status != '0) begin
					nxt.irq_cnt = st.irq_cnt + 1'b1;
					if (st.active) begin
						nxt.acc_status = st.acc_status | status;
						nxt.seen_gen = st.cur_gen;
					end
				end
			end
			FUNC_OBSERVE: begin
				if (tag_hit && st.enabled && st.active && st.seen_gen == tag) begin
					// error bits take priority over completion bits
					if ((st.acc_status & masks.err_mask) != '0)
						res.obs = OBS_ERROR;
					else if ((st.acc_status & masks.cmp_mask) != '0)
						res.obs = OBS_COMPLETE;
				end
			end
			FUNC_FINISH: begin
				if (tag_hit && st.active) begin
					nxt.active = 1'b0;
					nxt.seen_gen = '0;
					nxt.acc_status = '0;
					res.fin = 1'b1;
				end
			end
			FUNC_FALLBACK: begin
				nxt.fb_cnt = st.fb_cnt + 1'b1;
			end
			default: begin
				nxt = st;
			end
		endcase
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for irq_completion_tracker: a predictor of the tracker registers and a result checker.
// Depends on irqct_pkg, irqct_req_if, irqct_rsp_if and the tracker RTL.
module tb_top;
	import irqct_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		word_t new_gen;
		logic  fin;
		obs_t  obs;
		logic  en;
		logic  act;
		word_t acc;
		word_t irq;
		word_t fb;
	} tracker_out_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	word_t cfg_wdata;

	irqct_req_if req_ch();
	irqct_rsp_if rsp_ch();

	irq_completion_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predicted tracker registers and masks
	word_t pred_cur_gen    = '0;
	word_t pred_seen_gen   = '0;
	word_t pred_acc_status = '0;
	word_t pred_irq_cnt    = '0;
	word_t pred_fb_cnt     = '0;
	logic  pred_enabled    = 1'b0;
	logic  pred_active     = 1'b0;
	word_t pred_cmp_mask   = '0;
	word_t pred_err_mask   = '0;

	tracker_out_t tracker_outputs_due[$];

	int fail_count     = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int mask_settings  = 0;
	int gens_opened    = 0;
	int verdicts_seen  = 0;
	bit tx_gaps_on     = 1'b0;
	bit rx_stall_on    = 1'b0;
	int rx_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic word_t status_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, 31);
			3: return $urandom & pred_cmp_mask;
			4: return $urandom & pred_err_mask;
			default: return $urandom;
		endcase
	endfunction

	function automatic tracker_out_t step_tracker(func_t f, word_t status, word_t tag);
		tracker_out_t r;
		r.new_gen = '0;
		r.fin     = 1'b0;
		r.obs     = OBS_NONE;
		case (f)
			FUNC_CLEAR: begin
				pred_cur_gen    = '0;
				pred_seen_gen   = '0;
				pred_acc_status = '0;
				pred_irq_cnt    = '0;
				pred_fb_cnt     = '0;
				pred_enabled    = 1'b0;
				pred_active     = 1'b0;
			end
			FUNC_ENABLE: pred_enabled = 1'b1;
			FUNC_DISABLE: begin
				pred_enabled    = 1'b0;
				pred_active     = 1'b0;
				pred_seen_gen   = '0;
				pred_acc_status = '0;
			end
			FUNC_BEGIN: begin
				if (pred_enabled && !pred_active) begin
					// tag zero is reserved, so the counter skips it on wrap
					pred_cur_gen    = (pred_cur_gen == '1) ? word_t'(1) : pred_cur_gen + 1;
					pred_seen_gen   = '0;
					pred_acc_status = '0;
					pred_active     = 1'b1;
					r.new_gen       = pred_cur_gen;
					gens_opened++;
				end
			end
			FUNC_RECORD: begin
				if (pred_enabled && status != '0) begin
					pred_irq_cnt = pred_irq_cnt + 1;
					if (pred_active) begin
						pred_acc_status = pred_acc_status | status;
						pred_seen_gen   = pred_cur_gen;
					end
				end
			end
			FUNC_OBSERVE: begin
				if (tag != '0 && pred_enabled && pred_active &&
						pred_cur_gen == tag && pred_seen_gen == tag) begin
					if ((pred_acc_status & pred_err_mask) != '0)
						r.obs = OBS_ERROR;
					else if ((pred_acc_status & pred_cmp_mask) != '0)
						r.obs = OBS_COMPLETE;
				end
				if (r.obs != OBS_NONE)
					verdicts_seen++;
			end
			FUNC_FINISH: begin
				if (tag != '0 && pred_active && pred_cur_gen == tag) begin
					pred_active     = 1'b0;
					pred_seen_gen   = '0;
					pred_acc_status = '0;
					r.fin           = 1'b1;
				end
			end
			default: pred_fb_cnt = pred_fb_cnt + 1;
		endcase
		r.en  = pred_enabled;
		r.act = pred_active;
		r.acc = pred_acc_status;
		r.irq = pred_irq_cnt;
		r.fb  = pred_fb_cnt;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the request was taken.
	// valid stays high on return so back-to-back requests need no extra step.
	task automatic send_request(func_t f, word_t status, word_t tag);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= f;
		req_ch.status     <= status;
		req_ch.generation <= tag;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		tracker_outputs_due.push_back(step_tracker(f, status, tag));
		items_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (tracker_outputs_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_masks(word_t cmp, word_t err);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_COMPLETION_MASK;
		cfg_wdata <= cmp;
		@(posedge clk);
		cfg_index <= CFG_ERROR_MASK;
		cfg_wdata <= err;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_cmp_mask = cmp;
		pred_err_mask = err;
		mask_settings++;
		@(posedge clk);
	endtask

	task automatic check_field(string name, word_t want, word_t got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Mostly complete generations (begin, records, observe, finish) with random content,
	// mixed with wrong tags, early disables and random requests.
	task automatic run_sessions(int n);
		int start;
		word_t tag;
		start = items_sent;
		while (items_sent - start < n) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					tag = $urandom_range(0, 1) ? pred_cur_gen : word_t'($urandom);
					send_request(func_t'($urandom_range(0, 7)), status_word(), tag);
				end
				9: begin
					case ($urandom_range(0, 3))
						0: send_request(FUNC_CLEAR, $urandom, $urandom);
						1: send_request(FUNC_DISABLE, $urandom, $urandom);
						default: send_request(FUNC_ENABLE, $urandom, $urandom);
					endcase
				end
				default: begin
					if (!pred_enabled)
						send_request(FUNC_ENABLE, $urandom, $urandom);
					send_request(FUNC_BEGIN, $urandom, $urandom);
					repeat ($urandom_range(0, 4)) begin
						send_request(FUNC_RECORD, status_word(), $urandom);
						if ($urandom_range(0, 1))
							send_request(FUNC_OBSERVE, $urandom, pred_cur_gen);
					end
					case ($urandom_range(0, 7))
						0: send_request(FUNC_OBSERVE, $urandom, pred_cur_gen + 1);
						1: send_request(FUNC_FINISH, $urandom,
							pred_cur_gen ^ (word_t'(1) << $urandom_range(0, 31)));
						2: send_request(FUNC_DISABLE, $urandom, $urandom);
						default: ;
					endcase
					send_request(FUNC_OBSERVE, $urandom, pred_cur_gen);
					send_request(FUNC_FINISH, $urandom, pred_cur_gen);
				end
			endcase
		end
	endtask

	task automatic test_directed();
		tx_gaps_on  = 1'b0;
		rx_stall_on = 1'b0;
		set_masks(32'h0000_00FF, 32'hFF00_0000);
		send_request(FUNC_OBSERVE, 32'h0, 32'h1);          // disabled and idle
		send_request(FUNC_RECORD, 32'hFFFF_FFFF, 32'h0);   // ignored while disabled
		send_request(FUNC_BEGIN, 32'h0, 32'h0);            // refused: disabled
		send_request(FUNC_FINISH, 32'h0, 32'h1);           // idle
		send_request(FUNC_FALLBACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_ENABLE, 32'h0, 32'h0);
		send_request(FUNC_RECORD, 32'h0000_0010, 32'h0);   // counted, nothing active
		send_request(FUNC_BEGIN, 32'h0, 32'h0);
		send_request(FUNC_BEGIN, 32'h0, 32'h0);            // refused: already active
		send_request(FUNC_OBSERVE, 32'h0, 32'h1);          // nothing recorded yet
		send_request(FUNC_RECORD, 32'h0, 32'h0);           // zero status ignored
		send_request(FUNC_RECORD, 32'h0000_0001, 32'h0);
		send_request(FUNC_OBSERVE, 32'h0, 32'h0);          // zero tag
		send_request(FUNC_OBSERVE, 32'h0, 32'h2);          // wrong tag
		send_request(FUNC_OBSERVE, 32'h0, 32'h1);          // complete
		send_request(FUNC_RECORD, 32'h8000_0000, 32'h0);
		send_request(FUNC_OBSERVE, 32'h0, 32'h1);          // error wins over completion
		send_request(FUNC_FINISH, 32'h0, 32'hFFFF_FFFF);   // wrong tag
		send_request(FUNC_FINISH, 32'h0, 32'h1);
		send_request(FUNC_FINISH, 32'h0, 32'h1);           // already closed
		send_request(FUNC_BEGIN, 32'h0, 32'h0);
		send_request(FUNC_RECORD, 32'hFFFF_FFFF, 32'h0);
		send_request(FUNC_DISABLE, 32'h0, 32'h0);
		send_request(FUNC_OBSERVE, 32'h0, 32'h2);          // disabled
		send_request(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_mask_sweep();
		word_t cmp_list[7];
		word_t err_list[7];
		cmp_list = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0};
		err_list = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
		cmp_list[4] = word_t'(1) << $urandom_range(0, 31);
		err_list[4] = word_t'(1) << $urandom_range(0, 31);
		cmp_list[5] = $urandom;
		err_list[5] = $urandom & $urandom & $urandom;
		cmp_list[6] = $urandom;
		err_list[6] = $urandom;
		for (int i = 0; i < 7; i++) begin
			tx_gaps_on  = (i % 3) != 0;
			rx_stall_on = (i % 2) != 0;
			set_masks(cmp_list[i], err_list[i]);
			run_sessions(120);
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		tx_gaps_on     = 1'b0;
		rx_stall_on    = 1'b0;
		rx_hold_cycles = 80;
		// requests keep coming while results are held back, so intake stalls
		run_sessions(40);
		wait_drained();
		tx_gaps_on  = 1'b1;
		rx_stall_on = 1'b1;
		run_sessions(20);
		wait_drained();
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_COMPLETION_MASK;
		cfg_wdata         <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.func       <= FUNC_CLEAR;
		req_ch.status     <= '0;
		req_ch.generation <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mask_sweep();
		test_backpressure();
		wait_drained();

		if (tracker_outputs_due.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, tracker_outputs_due.size());
			fail_count++;
		end
		$display("Run covered %0d requests (%0d results) under %0d mask settings,",
			items_sent, results_seen, mask_settings);
		$display("with %0d generations opened and %0d observe verdicts.",
			gens_opened, verdicts_seen);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, plus a long hold when a test asks for one
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				stall_left     = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rx_stall_on && $urandom_range(0, 4) == 0)
					stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		tracker_out_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (tracker_outputs_due.size() == 0) begin
				$display("%0t ns: result with no request outstanding", $time);
				fail_count++;
			end else begin
				want = tracker_outputs_due.pop_front();
				check_field("new_generation", want.new_gen, rsp_ch.new_generation);
				check_field("finish_done", word_t'(want.fin), word_t'(rsp_ch.finish_done));
				check_field("observe_result", word_t'(want.obs), word_t'(rsp_ch.observe_result));
				check_field("enabled_now", word_t'(want.en), word_t'(rsp_ch.enabled_now));
				check_field("active_now", word_t'(want.act), word_t'(rsp_ch.active_now));
				check_field("status_seen", want.acc, rsp_ch.status_seen);
				check_field("interrupt_total", want.irq, rsp_ch.interrupt_total);
				check_field("fallback_total", want.fb, rsp_ch.fallback_total);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t ns: watchdog, no handshake for %0d cycles", $time, idle);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
